FILE: src/sfr_pkg.sv
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 2;
    localparam int ODATA_W = 24;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FLAG = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ESC  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ADDR = 2'd2;

    localparam logic [BYTE_W-1:0] RST_FLAG = 8'h5C;
    localparam logic [BYTE_W-1:0] RST_ESC  = 8'h5D;
    localparam logic [BYTE_W-1:0] RST_ADDR = 8'h03;

    // control field values
    localparam logic [BYTE_W-1:0] CTL_SET  = 8'h07;
    localparam logic [BYTE_W-1:0] CTL_DISC = 8'h0A;
    localparam logic [BYTE_W-1:0] CTL_I0   = 8'h80;
    localparam logic [BYTE_W-1:0] CTL_I1   = 8'hC0;
    localparam logic [BYTE_W-1:0] CTL_UA   = 8'h06;
    localparam logic [BYTE_W-1:0] CTL_RR0  = 8'h11;
    localparam logic [BYTE_W-1:0] CTL_RR1  = 8'h01;
    localparam logic [BYTE_W-1:0] CTL_REJ0 = 8'h15;
    localparam logic [BYTE_W-1:0] CTL_REJ1 = 8'h05;
    localparam logic [BYTE_W-1:0] STUFFED_FLAG = 8'h7C;
    localparam logic [BYTE_W-1:0] STUFFED_ESC  = 8'h7D;

    // event kinds
    localparam logic [KIND_W-1:0] EV_DATA   = 3'd0;
    localparam logic [KIND_W-1:0] EV_SET    = 3'd1;
    localparam logic [KIND_W-1:0] EV_ACCEPT = 3'd2;
    localparam logic [KIND_W-1:0] EV_REJECT = 3'd3;
    localparam logic [KIND_W-1:0] EV_DISC   = 3'd4;

    // frame types
    localparam logic [1:0] FT_SET  = 2'd0;
    localparam logic [1:0] FT_DISC = 2'd1;
    localparam logic [1:0] FT_I0   = 2'd2;
    localparam logic [1:0] FT_I1   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] flag;
        logic [BYTE_W-1:0] esc;
        logic [BYTE_W-1:0] addr;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] reply;
    } t_result;

    function automatic logic [BYTE_W-1:0] ctl_of_type(input logic [1:0] ft);
        logic [BYTE_W-1:0] c;
        unique case (ft)
            FT_SET:  c = CTL_SET;
            FT_DISC: c = CTL_DISC;
            FT_I0:   c = CTL_I0;
            default: c = CTL_I1;
        endcase
        return c;
    endfunction

endpackage

FILE: src/stuffed_frame_receiver.sv
// Top level of the stuffed frame receiver: input register, core, result register.
// Path: an accepted byte beat is held in the input register, decoded by the core
// combinationally and then captured as a result beat in the result register.
// Throughput: one byte per cycle unless the output stalls; the frame state updates
// from the input register; the result register drains in parallel with the next beat.
// Reset: synchronous, active low; clears the hunt state, pipeline valids and loads the
// default flag 0x5C, escape 0x5D and address 0x03.
module stuffed_frame_receiver
    import sfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [BYTE_W-1:0]  i_s_tdata,   // [7:0] rx_byte
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [ODATA_W-1:0] o_m_tdata,   // [2:0] event_kind, [10:3] data_byte,
                                            // [18:11] reply_control, [23:19] zero
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [BYTE_W-1:0]  i_cfg_data
);

    t_cfg              cfg;
    t_result           res;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;
    logic              advance;
    logic              step;

    assign advance    = !r_out_vld || i_m_tready;
    assign step       = r_in_vld && advance;
    assign o_s_tready = !r_in_vld || advance;

    sfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sfr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(ODATA_W - KIND_W - 2*BYTE_W){1'b0}},
                         r_out.reply, r_out.data, r_out.kind};

`ifndef SYNTHESIS
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= EV_DISC))
        else $error("event kind out of range");

    a_data_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] == EV_DATA) |-> (o_m_tdata[18:11] == '0))
        else $error("data beat carries a reply control");

    a_event_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] != EV_DATA) |-> (o_m_tdata[10:3] == '0))
        else $error("event beat carries a data byte");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("input register lost a stalled byte");
`endif

endmodule

FILE: src/sfr_cfg_regs.sv
// Configuration registers: flag, escape and address bytes.
module sfr_cfg_regs
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [BYTE_W-1:0] i_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag <= RST_FLAG;
            r_cfg.esc  <= RST_ESC;
            r_cfg.addr <= RST_ADDR;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_FLAG: r_cfg.flag <= i_data;
                CFG_ESC:  r_cfg.esc  <= i_data;
                CFG_ADDR: r_cfg.addr <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/sfr_core.sv
// Frame hunt, destuffing and check logic for one received byte per step.
module sfr_core
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    localparam logic [2:0] HS_START = 3'd0;
    localparam logic [2:0] HS_FLAG  = 3'd1;
    localparam logic [2:0] HS_ADDR  = 3'd2;
    localparam logic [2:0] HS_CTRL  = 3'd3;
    localparam logic [2:0] HS_SUPV  = 3'd4;
    localparam logic [2:0] HS_DATA  = 3'd5;

    logic [2:0]        r_hunt, n_hunt;
    logic [1:0]        r_ftype, n_ftype;
    logic              r_esc_pend, n_esc_pend;
    logic              r_held_vld, n_held_vld;
    logic [BYTE_W-1:0] r_held, n_held;
    logic [BYTE_W-1:0] r_xor, n_xor;

    logic              is_flag;
    logic              have;
    logic              one;
    logic [BYTE_W-1:0] dbyte;

    assign is_flag = (i_byte == i_cfg.flag);
    assign one     = (r_ftype == FT_I1);

    always_comb begin
        n_hunt     = r_hunt;
        n_ftype    = r_ftype;
        n_esc_pend = r_esc_pend;
        n_held_vld = r_held_vld;
        n_held     = r_held;
        n_xor      = r_xor;
        have       = 1'b0;
        dbyte      = '0;
        o_res      = '0;
        unique case (r_hunt)
            HS_FLAG: begin
                if (i_byte == i_cfg.addr) n_hunt = HS_ADDR;
                else if (is_flag)         n_hunt = HS_FLAG;
                else                      n_hunt = HS_START;
            end
            HS_ADDR: begin
                n_hunt = HS_CTRL;
                if (i_byte == CTL_SET)       n_ftype = FT_SET;
                else if (i_byte == CTL_DISC) n_ftype = FT_DISC;
                else if (i_byte == CTL_I0)   n_ftype = FT_I0;
                else if (i_byte == CTL_I1)   n_ftype = FT_I1;
                else if (is_flag)            n_hunt  = HS_FLAG;
                else                         n_hunt  = HS_START;
            end
            HS_CTRL: begin
                if (i_byte == (i_cfg.addr ^ ctl_of_type(r_ftype))) begin
                    if (r_ftype[1]) begin
                        n_hunt     = HS_DATA;
                        n_esc_pend = 1'b0;
                        n_held_vld = 1'b0;
                        n_held     = '0;
                        n_xor      = '0;
                    end else begin
                        n_hunt = HS_SUPV;
                    end
                end else if (is_flag) n_hunt = HS_FLAG;
                else                  n_hunt = HS_START;
            end
            HS_SUPV: begin
                n_hunt = HS_START;
                if (is_flag) begin
                    o_res.valid = 1'b1;
                    if (r_ftype == FT_SET) begin
                        o_res.kind  = EV_SET;
                        o_res.reply = CTL_UA;
                    end else begin
                        o_res.kind = EV_DISC;
                    end
                end
            end
            HS_DATA: begin
                if (is_flag) begin
                    // closing flag: the held byte is the check byte
                    n_hunt      = HS_START;
                    n_esc_pend  = 1'b0;
                    n_held_vld  = 1'b0;
                    o_res.valid = 1'b1;
                    if (r_held_vld && r_held == r_xor) begin
                        o_res.kind  = EV_ACCEPT;
                        o_res.reply = one ? CTL_RR1 : CTL_RR0;
                    end else begin
                        o_res.kind  = EV_REJECT;
                        o_res.reply = one ? CTL_REJ1 : CTL_REJ0;
                    end
                end else begin
                    if (r_esc_pend) begin
                        n_esc_pend = 1'b0;
                        if (i_byte == STUFFED_FLAG) begin
                            dbyte = i_cfg.flag;
                            have  = 1'b1;
                        end else if (i_byte == STUFFED_ESC) begin
                            dbyte = i_cfg.esc;
                            have  = 1'b1;
                        end
                    end else if (i_byte == i_cfg.esc) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        dbyte = i_byte;
                        have  = 1'b1;
                    end
                    if (have) begin
                        n_held_vld = 1'b1;
                        n_held     = dbyte;
                        if (r_held_vld) begin
                            n_xor       = r_xor ^ r_held;
                            o_res.valid = 1'b1;
                            o_res.kind  = EV_DATA;
                            o_res.data  = r_held;
                        end
                    end
                end
            end
            default: n_hunt = is_flag ? HS_FLAG : HS_START;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt     <= HS_START;
            r_ftype    <= FT_SET;
            r_esc_pend <= 1'b0;
            r_held_vld <= 1'b0;
            r_held     <= '0;
            r_xor      <= '0;
        end else if (i_step) begin
            r_hunt     <= n_hunt;
            r_ftype    <= n_ftype;
            r_esc_pend <= n_esc_pend;
            r_held_vld <= n_held_vld;
            r_held     <= n_held;
            r_xor      <= n_xor;
        end
    end

endmodule

FILE: tb/tb_stuffed_frame_receiver.sv
// Self-checking testbench for stuffed_frame_receiver: frame traffic, config sweeps, stalls.
module tb_stuffed_frame_receiver;
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        HUNT_START, HUNT_FLAG, HUNT_ADDR, HUNT_CTRL, HUNT_SUPV, HUNT_DATA
    } t_hunt;

    typedef enum logic [2:0] {
        FR_CLEAN, FR_BAD_CHECK, FR_NO_CHECK, FR_BAD_ESC, FR_OPEN_ESC, FR_BAD_HDR
    } t_frame_fault;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] reply;
    } t_rx_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [BYTE_W-1:0]  i_s_tdata = '0;     // [7:0] rx_byte
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [ODATA_W-1:0] o_m_tdata;          // [2:0] event_kind, [10:3] data_byte,
                                            // [18:11] reply_control, [23:19] zero
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [BYTE_W-1:0]  i_cfg_data = '0;

    stuffed_frame_receiver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver-side model state
    logic [BYTE_W-1:0] cfg_flag = RST_FLAG;
    logic [BYTE_W-1:0] cfg_esc  = RST_ESC;
    logic [BYTE_W-1:0] cfg_addr = RST_ADDR;
    t_hunt             hunt = HUNT_START;
    logic [BYTE_W-1:0] frame_ctl = CTL_SET;
    logic              esc_pending = 1'b0;
    logic              held_ok = 1'b0;
    logic [BYTE_W-1:0] held_byte = '0;
    logic [BYTE_W-1:0] run_xor = '0;

    t_rx_event pending_events[$];
    int        err_count = 0;
    int        items_sent = 0;

    // sender burst/gap and receiver stall controls
    int          burst_left = 0;
    int          gap_max = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          hold_left = 0;

    function automatic void push_event(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] data,
                                       input logic [BYTE_W-1:0] reply);
        t_rx_event ev;
        ev.kind = kind;
        ev.data = data;
        ev.reply = reply;
        pending_events.push_back(ev);
    endfunction

    function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        logic              have;
        logic              good;
        logic              odd;
        d = '0;
        have = 1'b0;
        case (hunt)
            HUNT_FLAG: begin
                if (b == cfg_addr) hunt = HUNT_ADDR;
                else if (b == cfg_flag) hunt = HUNT_FLAG;
                else hunt = HUNT_START;
            end
            HUNT_ADDR: begin
                if (b == CTL_SET || b == CTL_DISC || b == CTL_I0 || b == CTL_I1) begin
                    frame_ctl = b;
                    hunt = HUNT_CTRL;
                end else if (b == cfg_flag) begin
                    hunt = HUNT_FLAG;
                end else begin
                    hunt = HUNT_START;
                end
            end
            HUNT_CTRL: begin
                if (b == (cfg_addr ^ frame_ctl)) begin
                    if (frame_ctl == CTL_I0 || frame_ctl == CTL_I1) begin
                        hunt = HUNT_DATA;
                        esc_pending = 1'b0;
                        held_ok = 1'b0;
                        held_byte = '0;
                        run_xor = '0;
                    end else begin
                        hunt = HUNT_SUPV;
                    end
                end else if (b == cfg_flag) begin
                    hunt = HUNT_FLAG;
                end else begin
                    hunt = HUNT_START;
                end
            end
            HUNT_SUPV: begin
                hunt = HUNT_START;
                if (b == cfg_flag) begin
                    if (frame_ctl == CTL_SET) push_event(EV_SET, '0, CTL_UA);
                    else push_event(EV_DISC, '0, '0);
                end
            end
            HUNT_DATA: begin
                if (b == cfg_flag) begin
                    // raw flag always closes, even with an escape pending
                    good = held_ok && (held_byte == run_xor);
                    odd = (frame_ctl == CTL_I1);
                    hunt = HUNT_START;
                    esc_pending = 1'b0;
                    held_ok = 1'b0;
                    if (good) push_event(EV_ACCEPT, '0, odd ? CTL_RR1 : CTL_RR0);
                    else push_event(EV_REJECT, '0, odd ? CTL_REJ1 : CTL_REJ0);
                end else begin
                    if (esc_pending) begin
                        esc_pending = 1'b0;
                        if (b == STUFFED_FLAG) begin
                            d = cfg_flag;
                            have = 1'b1;
                        end else if (b == STUFFED_ESC) begin
                            d = cfg_esc;
                            have = 1'b1;
                        end
                    end else if (b == cfg_esc) begin
                        esc_pending = 1'b1;
                    end else begin
                        d = b;
                        have = 1'b1;
                    end
                    // bytes go out one late so the last one is kept as the check
                    if (have) begin
                        if (held_ok) begin
                            run_xor = run_xor ^ held_byte;
                            push_event(EV_DATA, held_byte, '0);
                        end
                        held_ok = 1'b1;
                        held_byte = d;
                    end
                end
            end
            default: hunt = (b == cfg_flag) ? HUNT_FLAG : HUNT_START;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        err_count++;
        if (err_count <= 100)
            $display("mismatch: %s got %02h want %02h at %0t", what, got, want, $time);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rx_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected beat, kind", BYTE_W'(o_m_tdata[2:0]), '0);
            end else begin
                want = pending_events.pop_front();
                if (o_m_tdata[2:0] != want.kind)
                    report_mismatch("event_kind", BYTE_W'(o_m_tdata[2:0]),
                                    BYTE_W'(want.kind));
                if (o_m_tdata[10:3] != want.data)
                    report_mismatch("data_byte", o_m_tdata[10:3], want.data);
                if (o_m_tdata[18:11] != want.reply)
                    report_mismatch("reply_control", o_m_tdata[18:11], want.reply);
            end
        end
    end

    // receiver: long hold when asked, else a rotating stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= stall_pattern[0];
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max > 0 && $urandom_range(0, 2) != 0) ? $urandom_range(1, gap_max) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        do @(posedge i_clk); while (!o_s_tready);
        track_rx_byte(b);
        items_sent++;
    endtask

    task automatic send_stuffed(input logic [BYTE_W-1:0] x);
        if (x == cfg_flag) begin
            send_byte(cfg_esc);
            send_byte(STUFFED_FLAG);
        end else if (x == cfg_esc) begin
            send_byte(cfg_esc);
            send_byte(STUFFED_ESC);
        end else begin
            send_byte(x);
        end
    endtask

    // payload bytes lean toward values that trigger stuffing and header matches
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0: r = cfg_flag;
            1: r = cfg_esc;
            2: r = STUFFED_FLAG;
            3: r = STUFFED_ESC;
            4: r = cfg_addr;
            5: r = CTL_I0;
            6: r = CTL_SET;
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] ctl, input int len,
                              input t_frame_fault fault);
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] x;
        int                cut;
        chk = '0;
        send_byte(cfg_flag);
        send_byte(cfg_addr);
        send_byte(ctl);
        send_byte(fault == FR_BAD_HDR ? pick_byte() : (cfg_addr ^ ctl));
        if (ctl == CTL_SET || ctl == CTL_DISC) begin
            // any fault leaves the supervisory frame unclosed
            send_byte(fault == FR_CLEAN ? cfg_flag : ~cfg_flag);
        end else begin
            cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
            for (int i = 0; i < len; i++) begin
                if (fault == FR_BAD_ESC && i == cut) begin
                    send_byte(cfg_esc);
                    x = BYTE_W'($urandom_range(0, 255));
                    send_byte(x);
                end
                x = pick_byte();
                chk = chk ^ x;
                send_stuffed(x);
            end
            case (fault)
                FR_BAD_CHECK: begin
                    x = BYTE_W'($urandom_range(1, 255));
                    send_stuffed(chk ^ x);
                end
                FR_NO_CHECK: ;
                FR_OPEN_ESC: begin
                    send_stuffed(chk);
                    send_byte(cfg_esc);
                end
                default: send_stuffed(chk);
            endcase
            send_byte(cfg_flag);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        // bytes with no result may still sit in the pipeline
        repeat (6) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FLAG: cfg_flag = val;
            CFG_ESC:  cfg_esc = val;
            default:  cfg_addr = val;
        endcase
    endtask

    task automatic apply_config(input logic [BYTE_W-1:0] flag_v,
                                input logic [BYTE_W-1:0] esc_v,
                                input logic [BYTE_W-1:0] addr_v);
        wait_idle();
        write_reg(CFG_FLAG, flag_v);
        write_reg(CFG_ESC, esc_v);
        write_reg(CFG_ADDR, addr_v);
    endtask

    task automatic randomize_idling();
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0) begin
            stall_pattern = 16'hFFFF;
        end else begin
            stall_pattern = 16'($urandom);
            stall_pattern[0] = 1'b1;
        end
    endtask

    task automatic run_random_frames(input int n_items);
        int                stop;
        int                r;
        int                len;
        logic [BYTE_W-1:0] ctl;
        t_frame_fault      fault;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_byte(pick_byte());
            end else begin
                if (r < 15) send_byte(cfg_flag);    // doubled opening flag
                case ($urandom_range(0, 5))
                    0:       ctl = CTL_SET;
                    1:       ctl = CTL_DISC;
                    2, 3:    ctl = CTL_I0;
                    default: ctl = CTL_I1;
                endcase
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                r = $urandom_range(0, 99);
                fault = (r < 60) ? FR_CLEAN :
                        (r < 72) ? FR_BAD_CHECK :
                        (r < 78) ? FR_NO_CHECK :
                        (r < 86) ? FR_BAD_ESC :
                        (r < 93) ? FR_OPEN_ESC : FR_BAD_HDR;
                send_frame(ctl, len, fault);
            end
        end
    endtask

    task automatic test_directed();
        gap_max = 0;
        stall_pattern = 16'hFFFF;
        send_frame(CTL_SET, 0, FR_CLEAN);
        send_frame(CTL_DISC, 0, FR_CLEAN);
        send_frame(CTL_DISC, 0, FR_BAD_CHECK);     // supervisory frame left open
        // I-frame 1: byte extremes, both stuffed forms, a dropped escape pair
        send_byte(cfg_flag);
        send_byte(cfg_addr);
        send_byte(CTL_I1);
        send_byte(cfg_addr ^ CTL_I1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_stuffed(cfg_flag);
        send_stuffed(cfg_esc);
        send_byte(cfg_esc);
        send_byte(8'h41);
        send_stuffed(8'hFF ^ cfg_flag ^ cfg_esc);
        send_byte(cfg_flag);
        // header fallback: flag restarts, unknown control drops to start
        send_byte(cfg_flag);
        send_byte(cfg_flag);
        send_byte(cfg_addr);
        send_byte(8'h55);
        // empty I-frame 0 closed while an escape is pending
        send_byte(cfg_flag);
        send_byte(cfg_addr);
        send_byte(CTL_I0);
        send_byte(cfg_addr ^ CTL_I0);
        send_byte(cfg_esc);
        send_byte(cfg_flag);
    endtask

    task automatic test_back_pressure();
        wait_idle();
        gap_max = 0;
        stall_pattern = 16'hFFFF;
        hold_left = 250;
        send_frame(CTL_I0, 40, FR_CLEAN);
        randomize_idling();
        run_random_frames(60);
    endtask

    task automatic test_config_extremes();
        apply_config(8'h00, 8'hFF, 8'hFF);
        randomize_idling();
        run_random_frames(120);
        apply_config(8'hFF, 8'h00, 8'h00);
        randomize_idling();
        run_random_frames(120);
        repeat (3) begin
            apply_config(pick_byte(), BYTE_W'($urandom_range(0, 255)), pick_byte());
            randomize_idling();
            run_random_frames(120);
        end
    endtask

    task automatic test_random_traffic();
        apply_config(RST_FLAG, RST_ESC, RST_ADDR);
        repeat (6) begin
            randomize_idling();
            run_random_frames(140);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_back_pressure();
        test_config_extremes();
        test_random_traffic();
        wait_idle();
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
